### hdl/ccorr_pkg.sv
// ----------------------------------------------------------------------------
// ccorr_pkg
// Shared constants and types of the complex cross-correlation block.
// ----------------------------------------------------------------------------
package ccorr_pkg;

  localparam int MAX_LEN     = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 38;
  localparam int CNT_BITS    = 6;
  localparam int ADDR_BITS   = $clog2(MAX_LEN);
  localparam int SMP_BITS    = 2 * SAMPLE_BITS;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int TERM_BITS   = PROD_BITS + 1;

  localparam logic [CNT_BITS-1:0] LEN_RESET = CNT_BITS'(32);

  // One issued term travelling down the MAC pipeline
  typedef struct packed {
    logic                vld;
    logic                term;
    logic                first;
    logic                lasti;
    logic                lastt;
    logic [CNT_BITS-1:0] tau;
  } iss_t;

endpackage

### hdl/ccorr_ram.sv
// ----------------------------------------------------------------------------
// ccorr_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ccorr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/ccorr_seq.sv
// ----------------------------------------------------------------------------
// ccorr_seq
// Load counter, length register and term sequencer. Walks every (tau, i)
// pair of a run and issues sample memory reads, one term per cycle unless stalled.
// ----------------------------------------------------------------------------
module ccorr_seq
  import ccorr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cfg_we,
  input  logic [CNT_BITS-1:0]  cfg_wdata,
  input  logic                 adv,
  output logic                 wr_en,
  output logic [ADDR_BITS-1:0] wr_addr,
  output logic [ADDR_BITS-1:0] rd_addr_a,
  output logic [ADDR_BITS-1:0] rd_addr_b,
  output iss_t                 iss
);

  logic [CNT_BITS-1:0]  sample_count_r;
  logic [ADDR_BITS-1:0] load_cnt_r, load_cnt_nxt;
  logic                 run_r, run_nxt;
  logic [ADDR_BITS-1:0] i_r, i_nxt;
  logic [CNT_BITS-1:0]  tau_r, tau_nxt;
  iss_t                 iss_r, iss_nxt;

  logic [CNT_BITS-1:0]  len;
  logic [CNT_BITS-1:0]  nm1;
  logic [CNT_BITS-1:0]  n2m1;
  logic [CNT_BITS-1:0]  i_ext;
  logic [CNT_BITS:0]    sum;
  logic [CNT_BITS:0]    off;
  logic                 term;
  logic                 lasti;
  logic                 lastt;
  logic                 load_done;

  // Clamp the length into 1..MAX_LEN
  always_comb begin
    if (sample_count_r == '0) begin
      len = CNT_BITS'(1);
    end else if (sample_count_r > CNT_BITS'(MAX_LEN)) begin
      len = CNT_BITS'(MAX_LEN);
    end else begin
      len = sample_count_r;
    end
  end

  assign nm1   = len - CNT_BITS'(1);
  assign n2m1  = {nm1[CNT_BITS-2:0], 1'b0};
  assign i_ext = {{(CNT_BITS-ADDR_BITS){1'b0}}, i_r};
  assign sum   = {1'b0, i_ext} + {1'b0, tau_r};
  assign off   = sum - {1'b0, nm1};
  // a sits at offset N-1 of the padded buffer; outside it the term is zero
  assign term  = (sum >= {1'b0, nm1}) && (sum <= {nm1, 1'b0});
  assign lasti = (i_ext == nm1);
  assign lastt = (tau_r == n2m1);

  assign in_ready  = !run_r;
  assign wr_en     = in_valid && in_ready;
  assign wr_addr   = load_cnt_r;
  assign rd_addr_a = off[ADDR_BITS-1:0];
  assign rd_addr_b = i_r;
  assign load_done = ({{(CNT_BITS-ADDR_BITS){1'b0}}, load_cnt_r} + CNT_BITS'(1)) == len;
  assign iss       = iss_r;

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    run_nxt      = run_r;
    i_nxt        = i_r;
    tau_nxt      = tau_r;
    iss_nxt      = iss_r;

    if (cfg_we) begin
      load_cnt_nxt = '0;
    end else if (wr_en) begin
      if (load_done) begin
        load_cnt_nxt = '0;
        run_nxt      = 1'b1;
        i_nxt        = '0;
        tau_nxt      = '0;
      end else begin
        load_cnt_nxt = load_cnt_r + ADDR_BITS'(1);
      end
    end

    if (adv) begin
      iss_nxt.vld   = run_r;
      iss_nxt.term  = term;
      iss_nxt.first = (i_r == '0);
      iss_nxt.lasti = lasti;
      iss_nxt.lastt = lastt;
      iss_nxt.tau   = tau_r;
      if (run_r) begin
        // advance to the next term, then the next lag
        if (lasti) begin
          i_nxt = '0;
          if (lastt) begin
            run_nxt = 1'b0;
          end else begin
            tau_nxt = tau_r + CNT_BITS'(1);
          end
        end else begin
          i_nxt = i_r + ADDR_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= LEN_RESET;
      load_cnt_r     <= '0;
      run_r          <= 1'b0;
      i_r            <= '0;
      tau_r          <= '0;
      iss_r          <= '0;
    end else begin
      if (cfg_we) begin
        sample_count_r <= cfg_wdata;
      end
      load_cnt_r <= load_cnt_nxt;
      run_r      <= run_nxt;
      i_r        <= i_nxt;
      tau_r      <= tau_nxt;
      iss_r      <= iss_nxt;
    end
  end

  // The issue pass always ends on the final term of the final lag
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(run_r) |-> iss_r.vld && iss_r.lasti && iss_r.lastt)
    else $error("issue pass ended early");

endmodule

### hdl/ccorr_mac.sv
// ----------------------------------------------------------------------------
// ccorr_mac
// Complex multiply by the conjugate, term sum, accumulator and result
// register. The whole pipeline freezes while a finished sum cannot be placed.
// ----------------------------------------------------------------------------
module ccorr_mac
  import ccorr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  iss_t                       iss,
  input  logic [SMP_BITS-1:0]        a_rdata,
  input  logic [SMP_BITS-1:0]        b_rdata,
  output logic                       adv,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CNT_BITS-1:0]        out_lag_index,
  output logic signed [ACC_BITS-1:0] out_corr_re,
  output logic signed [ACC_BITS-1:0] out_corr_im,
  output logic                       out_last
);

  logic signed [SAMPLE_BITS-1:0] a_re, a_im, b_re, b_im;

  iss_t                         m_ctl_r;
  logic signed [PROD_BITS-1:0]  m_rr_r, m_ii_r, m_ir_r, m_ri_r;
  iss_t                         t_ctl_r;
  logic signed [TERM_BITS-1:0]  t_re_r, t_im_r;
  logic signed [ACC_BITS-1:0]   acc_re_r, acc_im_r;
  logic signed [ACC_BITS-1:0]   acc_re_nxt, acc_im_nxt;
  logic                         out_valid_r;
  logic [CNT_BITS-1:0]          out_lag_index_r;
  logic signed [ACC_BITS-1:0]   out_corr_re_r, out_corr_im_r;
  logic                         out_last_r;
  logic                         stall;
  logic                         put;

  assign a_re = a_rdata[SMP_BITS-1:SAMPLE_BITS];
  assign a_im = a_rdata[SAMPLE_BITS-1:0];
  assign b_re = b_rdata[SMP_BITS-1:SAMPLE_BITS];
  assign b_im = b_rdata[SAMPLE_BITS-1:0];

  // Hold everything while a finished sum waits and the result register is full and not drained
  assign stall = t_ctl_r.vld && t_ctl_r.lasti && out_valid_r && !out_ready;
  assign adv   = !stall;
  assign put   = t_ctl_r.vld && t_ctl_r.lasti && adv;

  always_comb begin
    acc_re_nxt = (t_ctl_r.first ? '0 : acc_re_r)
               + {{(ACC_BITS-TERM_BITS){t_re_r[TERM_BITS-1]}}, t_re_r};
    acc_im_nxt = (t_ctl_r.first ? '0 : acc_im_r)
               + {{(ACC_BITS-TERM_BITS){t_im_r[TERM_BITS-1]}}, t_im_r};
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      if (iss.term) begin
        m_rr_r <= a_re * b_re;
        m_ii_r <= a_im * b_im;
        m_ir_r <= a_im * b_re;
        m_ri_r <= a_re * b_im;
      end else begin
        // drop terms that fall in the zero padding
        m_rr_r <= '0;
        m_ii_r <= '0;
        m_ir_r <= '0;
        m_ri_r <= '0;
      end
      t_re_r <= {m_rr_r[PROD_BITS-1], m_rr_r} + {m_ii_r[PROD_BITS-1], m_ii_r};
      t_im_r <= {m_ir_r[PROD_BITS-1], m_ir_r} - {m_ri_r[PROD_BITS-1], m_ri_r};
      if (t_ctl_r.vld) begin
        acc_re_r <= acc_re_nxt;
        acc_im_r <= acc_im_nxt;
      end
    end
    if (put) begin
      out_lag_index_r <= t_ctl_r.tau;
      out_corr_re_r   <= acc_re_nxt;
      out_corr_im_r   <= acc_im_nxt;
      out_last_r      <= t_ctl_r.lastt;
    end
  end

  // Control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_ctl_r     <= '0;
      t_ctl_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        m_ctl_r <= iss;
        t_ctl_r <= m_ctl_r;
      end
      if (put) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lag_index = out_lag_index_r;
  assign out_corr_re   = out_corr_re_r;
  assign out_corr_im   = out_corr_im_r;
  assign out_last      = out_last_r;

  a_put_lag: assert property (@(posedge clk) disable iff (!rst_n)
    put |=> out_valid_r && (out_lag_index_r == $past(t_ctl_r.tau)))
    else $error("finished sum not placed in result register");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    m_ctl_r.vld && !m_ctl_r.term |-> (m_rr_r == '0) && (m_ii_r == '0)
                                   && (m_ir_r == '0) && (m_ri_r == '0))
    else $error("padding term not zeroed");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> t_ctl_r == $past(t_ctl_r))
    else $error("pipeline advanced during stall");

endmodule

### hdl/complex_cross_correlation.sv
// Results: the word that ends the load of N pairs starts the issue pass; each
//   lag's sum goes via the issue, product and term registers to the result.
// Work: one run takes N loading words plus N*(2N-1) terms of the single complex
//   MAC, which reads one term a cycle from both sample memories unless stalled.
// Reset: synchronous, active low; length returns to 32, load count to zero,
//   sample memories keep their contents.
// ----------------------------------------------------------------------------
// complex_cross_correlation
// Time-domain complex cross-correlation of two loaded signals, Q1.15 samples,
// full-precision 38-bit sums.
// ----------------------------------------------------------------------------
module complex_cross_correlation
  import ccorr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_a_re,
  input  logic signed [SAMPLE_BITS-1:0] in_a_im,
  input  logic signed [SAMPLE_BITS-1:0] in_b_re,
  input  logic signed [SAMPLE_BITS-1:0] in_b_im,
  input  logic                          cfg_we,
  input  logic [CNT_BITS-1:0]           cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CNT_BITS-1:0]           out_lag_index,
  output logic signed [ACC_BITS-1:0]    out_corr_re,
  output logic signed [ACC_BITS-1:0]    out_corr_im,
  output logic                          out_last
);

  logic                 adv;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [ADDR_BITS-1:0] rd_addr_a;
  logic [ADDR_BITS-1:0] rd_addr_b;
  logic [SMP_BITS-1:0]  a_rdata;
  logic [SMP_BITS-1:0]  b_rdata;
  iss_t                 iss;

  ccorr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .iss       (iss)
  );

  ccorr_ram #(.WIDTH(SMP_BITS), .DEPTH(MAX_LEN)) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_a_re, in_a_im}),
    .re    (adv),
    .raddr (rd_addr_a),
    .rdata (a_rdata)
  );

  ccorr_ram #(.WIDTH(SMP_BITS), .DEPTH(MAX_LEN)) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_b_re, in_b_im}),
    .re    (adv),
    .raddr (rd_addr_b),
    .rdata (b_rdata)
  );

  ccorr_mac u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .iss           (iss),
    .a_rdata       (a_rdata),
    .b_rdata       (b_rdata),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_lag_index (out_lag_index),
    .out_corr_re   (out_corr_re),
    .out_corr_im   (out_corr_im),
    .out_last      (out_last)
  );

endmodule
